@@ hw/rtl/wrp_pkg.sv @@
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and codes of the waypoint record and playback core.
// ----------------------------------------------------------------------------
package wrp_pkg;

  // Command codes carried on func_i and echoed on ack_o.
  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_STOP  = 3'd1,
    FUNC_SAVE  = 3'd2,
    FUNC_RESET = 3'd3,
    FUNC_RUN   = 3'd4,
    FUNC_CLEAR = 3'd5
  } func_e;

  // Playback step outcome codes.
  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_MOVED = 2'd1,
    STEP_DONE  = 2'd2
  } step_e;

  localparam int unsigned JointW = 16;

  // One stored arm pose, six joint values.
  typedef struct packed {
    logic [JointW-1:0] base_rotation;
    logic [JointW-1:0] base_elevation;
    logic [JointW-1:0] elbow;
    logic [JointW-1:0] wrist_pitch;
    logic [JointW-1:0] wrist_roll;
    logic [JointW-1:0] grabber;
  } pose_t;

  // Reset value of the active slot count register.
  localparam logic [6:0] ActiveSlotsRst = 7'd64;

endpackage

@@ hw/rtl/wrp_store.sv @@
// ----------------------------------------------------------------------------
// wrp_store
// Waypoint memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module wrp_store
  import wrp_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  pose_t                      wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output pose_t                      rdata_o
);

  pose_t mem_q [DEPTH];
  pose_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/waypoint_record_playback_core.sv @@
// ----------------------------------------------------------------------------
// waypoint_record_playback_core
// Records six-joint arm poses on a stack and plays them back step by step.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low; busy_o is then
// high for one cycle, and in that same cycle the result word appears for
// exactly one cycle with result_valid_o high. The result word waits for
// the registered read data of the waypoint memory, which a playback step
// reads for the pose it outputs. The receiver cannot stall the block, so it
// must take every result word in the cycle it is shown. A tick while
// playback is not armed, and an unknown command code, still raise busy_o
// but produce no result word.
// active_slots is written through cfg_we_i / cfg_wdata_i and should only be
// changed while busy_o is low.
// ----------------------------------------------------------------------------
module waypoint_record_playback_core
  import wrp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,

  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] in_base_rotation_i,
  input  logic [15:0] in_base_elevation_i,
  input  logic [15:0] in_elbow_i,
  input  logic [15:0] in_wrist_pitch_i,
  input  logic [15:0] in_wrist_roll_i,
  input  logic [15:0] in_grabber_i,

  output logic        result_valid_o,
  output logic [2:0]  ack_o,
  output logic [1:0]  step_outcome_o,
  output logic        save_fault_o,
  output logic [15:0] out_base_rotation_o,
  output logic [15:0] out_base_elevation_o,
  output logic [15:0] out_elbow_o,
  output logic [15:0] out_wrist_pitch_o,
  output logic [15:0] out_wrist_roll_o,
  output logic [15:0] out_grabber_o,
  output logic [5:0]  position_index_o,
  output logic [6:0]  points_remaining_o
);

  // Index width, fill count width, and a compare width that holds the
  // configuration register, the depth and any step target.
  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned NW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = (((IW + 1) > 7) ? (IW + 1) : 7) + 1;
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  // Architectural state. The poses themselves live in the waypoint memory.
  logic [6:0]             as_q;
  logic [NW-1:0]          nf_q, nf_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic                   back_q, back_d;
  logic                   play_q, play_d;
  logic [STACK_DEPTH-1:0] used_q, used_d;

  // Result word bookkeeping.
  logic                   busy_q;
  logic                   rv_q, rv_d;
  logic [2:0]             ack_q;
  step_e                  outcome_q, outcome_d;
  logic                   fault_q, fault_d;

  logic    accept;
  func_e   func;
  logic    step_back;
  logic [IW:0] tgt;
  logic [CW-1:0] tgt_c, nf_c, as_c;
  logic    step_ok;
  logic    step_re;
  logic    save_we;
  pose_t   in_pose;
  pose_t   rd_pose;

  assign accept = start_i && !busy_q;
  assign func   = func_e'(func_i);

  assign in_pose = '{
    base_rotation:  in_base_rotation_i,
    base_elevation: in_base_elevation_i,
    elbow:          in_elbow_i,
    wrist_pitch:    in_wrist_pitch_i,
    wrist_roll:     in_wrist_roll_i,
    grabber:        in_grabber_i
  };

  // A run always steps forward; a tick follows the stored direction.
  assign step_back = (func == FUNC_RUN) ? 1'b0 : back_q;
  assign tgt       = step_back ? ({1'b0, cur_q} - 1'b1) : ({1'b0, cur_q} + 1'b1);
  assign tgt_c     = CW'(tgt);
  assign nf_c      = CW'(nf_q);
  assign as_c      = CW'(as_q);

  // The target must lie below both the active slot count and the depth and
  // must hold a recorded pose. Stepping back from slot zero ends playback.
  assign step_ok = !(step_back && (cur_q == '0)) && (tgt_c < as_c) &&
                   (tgt_c < DepthC) && used_q[tgt[IW-1:0]];

  // Command decode: compute the next architectural state and result word.
  always_comb begin
    nf_d      = nf_q;
    cur_d     = cur_q;
    back_d    = back_q;
    play_d    = play_q;
    used_d    = used_q;
    rv_d      = 1'b0;
    outcome_d = STEP_NONE;
    fault_d   = 1'b0;
    step_re   = 1'b0;
    save_we   = 1'b0;
    if (accept) begin
      unique case (func)
        FUNC_TICK: begin
          if (play_q) begin
            rv_d    = 1'b1;
            step_re = step_ok;
            if (step_ok) begin
              cur_d     = tgt[IW-1:0];
              outcome_d = STEP_MOVED;
            end else begin
              outcome_d = STEP_DONE;
            end
            play_d = step_ok;
          end
        end
        FUNC_STOP: begin
          rv_d   = 1'b1;
          play_d = 1'b0;
        end
        FUNC_SAVE: begin
          rv_d   = 1'b1;
          play_d = 1'b0;
          if ((nf_c < as_c) && (nf_c < DepthC)) begin
            if (used_q[nf_q[IW-1:0]]) begin
              fault_d = 1'b1;
            end else begin
              save_we                = 1'b1;
              used_d[nf_q[IW-1:0]]   = 1'b1;
              cur_d                  = nf_q[IW-1:0];
              nf_d                   = nf_q + 1'b1;
            end
          end
        end
        FUNC_RESET: begin
          rv_d   = 1'b1;
          back_d = 1'b1;
          play_d = 1'b1;
        end
        FUNC_RUN: begin
          rv_d    = 1'b1;
          back_d  = 1'b0;
          step_re = step_ok;
          if (step_ok) begin
            cur_d     = tgt[IW-1:0];
            outcome_d = STEP_MOVED;
          end else begin
            outcome_d = STEP_DONE;
          end
          play_d = step_ok;
        end
        FUNC_CLEAR: begin
          rv_d   = 1'b1;
          play_d = 1'b0;
          if (nf_q != '0) begin
            nf_d = nf_q - 1'b1;
            used_d[nf_d[IW-1:0]] = 1'b0;
            cur_d = (cur_q != '0) ? (cur_q - 1'b1) : '0;
          end
        end
        default: begin
          // Unknown codes produce nothing and change nothing.
          rv_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      as_q      <= ActiveSlotsRst;
      nf_q      <= '0;
      cur_q     <= '0;
      back_q    <= 1'b0;
      play_q    <= 1'b0;
      used_q    <= '0;
      busy_q    <= 1'b0;
      rv_q      <= 1'b0;
      outcome_q <= STEP_NONE;
      fault_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        as_q <= cfg_wdata_i;
      end
      nf_q      <= nf_d;
      cur_q     <= cur_d;
      back_q    <= back_d;
      play_q    <= play_d;
      used_q    <= used_d;
      busy_q    <= accept;
      rv_q      <= rv_d;
      outcome_q <= outcome_d;
      fault_q   <= fault_d;
    end
  end

  // The echoed command code is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ack_q <= func_i;
    end
  end

  wrp_store #(
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (save_we),
    .waddr_i (nf_q[IW-1:0]),
    .wdata_i (in_pose),
    .re_i    (step_re),
    .raddr_i (tgt[IW-1:0]),
    .rdata_o (rd_pose)
  );

  // Result word. Index and fill count are taken straight from the state,
  // which holds still until the next command is taken.
  logic [IW+5:0] pos_ext;
  logic [NW+6:0] pts_ext;
  pose_t         out_pose;

  assign pos_ext  = {6'd0, cur_q};
  assign pts_ext  = (NW + 7)'(STACK_DEPTH) - {7'd0, nf_q};
  assign out_pose = (outcome_q == STEP_MOVED) ? rd_pose : '0;

  assign busy_o               = busy_q;
  assign result_valid_o       = rv_q;
  assign ack_o                = ack_q;
  assign step_outcome_o       = outcome_q;
  assign save_fault_o         = fault_q;
  assign out_base_rotation_o  = out_pose.base_rotation;
  assign out_base_elevation_o = out_pose.base_elevation;
  assign out_elbow_o          = out_pose.elbow;
  assign out_wrist_pitch_o    = out_pose.wrist_pitch;
  assign out_wrist_roll_o     = out_pose.wrist_roll;
  assign out_grabber_o        = out_pose.grabber;
  assign position_index_o     = pos_ext[5:0];
  assign points_remaining_o   = pts_ext[6:0];

  // A result word is only ever shown in the cycle after a taken command.
  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o))
    else $error("result word without a taken command");

  // The block is busy for exactly one cycle after each command.
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held for more than one cycle");

  // A playback step only ever lands on a recorded slot.
  a_moved_to_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (step_outcome_o == STEP_MOVED)) |-> used_q[cur_q])
    else $error("playback moved to an unused slot");

  // The fill count never passes the stack depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(nf_q) <= DepthC)
    else $error("fill count beyond stack depth");

endmodule
